// ===== rtl/cvtg_pkg.sv =====
`timescale 1ns / 1ps

package cvtg_pkg;

  localparam int ByteCountW = 12;
  localparam int LineCountW = 11;
  localparam int HRegW      = 11;
  localparam int VRegW      = 10;
  localparam int CfgDataW   = 11;
  localparam int CfgIndexW  = 3;
  localparam int PixelW     = 8;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ACTIVE_BYTES = 3'd0,
    REG_LINE_WRAP    = 3'd1,
    REG_ACTIVE_FIRST = 3'd2,
    REG_ACTIVE_END   = 3'd3,
    REG_SYNC_LINES   = 3'd4,
    REG_FRAME_WRAP   = 3'd5
  } cfg_reg_t;

  localparam logic [HRegW-1:0] ActiveBytesRst = 11'd1280;
  localparam logic [HRegW-1:0] LineWrapRst    = 11'd1568;
  localparam logic [VRegW-1:0] ActiveFirstRst = 10'd17;
  localparam logic [VRegW-1:0] ActiveEndRst   = 10'd497;
  localparam logic [VRegW-1:0] SyncLinesRst   = 10'd3;
  localparam logic [VRegW-1:0] FrameWrapRst   = 10'd510;

  localparam logic [ByteCountW-1:0] Bar1End = 12'd160;
  localparam logic [ByteCountW-1:0] Bar2End = 12'd220;
  localparam logic [ByteCountW-1:0] Bar3End = 12'd320;
  localparam logic [PixelW-1:0]     Bar1Y   = 8'd64;
  localparam logic [PixelW-1:0]     Bar2Y   = 8'd128;
  localparam logic [PixelW-1:0]     Bar3Y   = 8'd192;
  localparam logic [PixelW-1:0]     Bar4Y   = 8'd255;

  typedef struct packed {
    logic [HRegW-1:0] active_bytes;
    logic [HRegW-1:0] line_wrap;
    logic [VRegW-1:0] active_first;
    logic [VRegW-1:0] active_end;
    logic [VRegW-1:0] sync_lines;
    logic [VRegW-1:0] frame_wrap;
  } cfg_t;

  typedef struct packed {
    logic              line_valid;
    logic              frame_sync;
    logic [PixelW-1:0] pixel_byte;
  } beat_t;

  function automatic logic [PixelW-1:0] bar_luma(input logic [ByteCountW-1:0] pos);
    logic [PixelW-1:0] y;
    if (pos < Bar1End) y = Bar1Y;
    else if (pos < Bar2End) y = Bar2Y;
    else if (pos < Bar3End) y = Bar3Y;
    else y = Bar4Y;
    return y;
  endfunction

endpackage

// ===== rtl/cvtg_cfg_regs.sv =====
`timescale 1ns / 1ps

module cvtg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cvtg_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cvtg_pkg::CfgDataW-1:0]  cfg_data,
  output cvtg_pkg::cfg_t                 cfg
);
  import cvtg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_bytes <= ActiveBytesRst;
      cfg.line_wrap    <= LineWrapRst;
      cfg.active_first <= ActiveFirstRst;
      cfg.active_end   <= ActiveEndRst;
      cfg.sync_lines   <= SyncLinesRst;
      cfg.frame_wrap   <= FrameWrapRst;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_BYTES: cfg.active_bytes <= cfg_data[HRegW-1:0];
        REG_LINE_WRAP:    cfg.line_wrap    <= cfg_data[HRegW-1:0];
        REG_ACTIVE_FIRST: cfg.active_first <= cfg_data[VRegW-1:0];
        REG_ACTIVE_END:   cfg.active_end   <= cfg_data[VRegW-1:0];
        REG_SYNC_LINES:   cfg.sync_lines   <= cfg_data[VRegW-1:0];
        REG_FRAME_WRAP:   cfg.frame_wrap   <= cfg_data[VRegW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cvtg_timing.sv =====
`timescale 1ns / 1ps

module cvtg_timing (
  input  logic            clk,
  input  logic            rst,
  input  cvtg_pkg::cfg_t  cfg,
  input  logic            advance,
  input  logic            tick,
  output cvtg_pkg::beat_t result
);
  import cvtg_pkg::*;

  logic [ByteCountW-1:0] byte_counter;
  logic [LineCountW-1:0] line_counter;
  logic [1:0]            byte_phase;
  beat_t                 held;

  logic [ByteCountW-1:0] byte_inc;
  logic [ByteCountW-1:0] byte_counter_next;
  logic [LineCountW-1:0] line_step;
  logic [LineCountW-1:0] line_counter_next;
  logic                  line_adv;
  beat_t                 held_next;

  always_comb begin
    byte_inc  = byte_counter + 1'b1;
    line_adv  = byte_inc > {1'b0, cfg.line_wrap};
    byte_counter_next = line_adv ? '0 : byte_inc;
    line_step = line_adv ? line_counter + 1'b1 : line_counter;
    line_counter_next = (line_step > {1'b0, cfg.frame_wrap}) ? '0 : line_step;

    held_next.line_valid = (byte_inc < {1'b0, cfg.active_bytes}) &&
                           (line_counter > {1'b0, cfg.active_first}) &&
                           (line_counter < {1'b0, cfg.active_end});
    held_next.frame_sync = line_step < {1'b0, cfg.sync_lines};
    held_next.pixel_byte = byte_phase[0] ? '0 : bar_luma(byte_counter_next);
  end

  assign result = tick ? held_next : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
      line_counter <= '0;
      byte_phase   <= '0;
      held         <= '0;
    end else if (advance && tick) begin
      byte_counter <= byte_counter_next;
      line_counter <= line_counter_next;
      byte_phase   <= byte_phase + 1'b1;
      held         <= held_next;
    end
  end

endmodule

// ===== rtl/cvtg_out_buf.sv =====
`timescale 1ns / 1ps

module cvtg_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  cvtg_pkg::beat_t din,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output cvtg_pkg::beat_t dout
);
  import cvtg_pkg::*;

  logic  skid_valid;
  beat_t skid;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      dout <= skid_valid ? skid : din;
    end
    if (load && out_valid && !out_ready) begin
      skid <= din;
    end
  end

endmodule

// ===== rtl/camera_video_timing_generator_core.sv =====
`timescale 1ns / 1ps

// Camera video timing source with a four-bar YUV 4:2:2 test pattern.
// Input channel: one beat per pixel-clock step; tick=1 advances the byte,
// line and phase counters, tick=0 repeats the last active outputs.
// Output channel: one beat per input beat carrying line_valid, frame_sync
// and pixel_byte (Y, U, Y, V order; U and V are zero).
// Each accepted beat's result is registered, in the output or skid stage.
// Throughput: one beat per cycle while the receiver keeps up, set by the
// counter update feeding a registered output stage.
// When the receiver stalls, one further beat is caught in a skid register,
// after which in_ready drops until the output drains; no beat is lost.
// Configuration: cfg_write with cfg_index 0..5 sets active_bytes,
// line_wrap, active_first, active_end, sync_lines, frame_wrap; write only
// while idle. Other indexes are ignored.
// Reset: counters and held outputs clear to zero, registers take their
// defaults, both channels empty.

module camera_video_timing_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           line_valid,
  output logic                           frame_sync,
  output logic [cvtg_pkg::PixelW-1:0]    pixel_byte,
  input  logic                           cfg_write,
  input  logic [cvtg_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cvtg_pkg::CfgDataW-1:0]  cfg_data
);
  import cvtg_pkg::*;

  cfg_t  cfg;
  beat_t result;
  beat_t dout;
  logic  accept;

  assign accept = in_valid && in_ready;

  cvtg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvtg_timing u_timing (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (accept),
    .tick    (tick),
    .result  (result)
  );

  cvtg_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .din       (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign line_valid = dout.line_valid;
  assign frame_sync = dout.frame_sync;
  assign pixel_byte = dout.pixel_byte;

endmodule

// ===== bench/camera_video_timing_generator_core_test.sv =====
`timescale 1ns / 1ps

module camera_video_timing_generator_core_test;
  import cvtg_pkg::*;

  localparam int NumRegs   = 6;
  localparam int IdleLimit = 2000;
  localparam int LongHold  = 120;
  localparam int NumFixed  = 5;
  localparam int NumRandom = 9;
  localparam int RandomLen = 90;
  localparam int NumRows   = 20;

  typedef struct packed {
    bit    tick;
    bit    known;
    beat_t want;
  } step_row_t;

  // Default registers after reset: line 0 is a sync line, never a valid line.
  localparam step_row_t DirectedRows [NumRows] = '{
    '{1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
    '{1'b1, 1'b1, '{1'b0, 1'b1, 8'd64}},
    '{1'b0, 1'b1, '{1'b0, 1'b1, 8'd64}},
    '{1'b1, 1'b1, '{1'b0, 1'b1, 8'd0}},
    '{1'b1, 1'b1, '{1'b0, 1'b1, 8'd64}},
    '{1'b1, 1'b1, '{1'b0, 1'b1, 8'd0}},
    '{1'b1, 1'b1, '{1'b0, 1'b1, 8'd64}},
    '{1'b0, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0}
  };

  // Fields: active_bytes, line_wrap, active_first, active_end, sync_lines, frame_wrap.
  localparam cfg_t FixedCfg [NumFixed] = '{
    '{11'd6,    11'd9,    10'd1,    10'd5,    10'd2,    10'd6},
    '{11'd0,    11'd0,    10'd0,    10'd0,    10'd0,    10'd0},
    '{11'd330,  11'd329,  10'd0,    10'd3,    10'd2,    10'd2},
    '{11'd2047, 11'd0,    10'd0,    10'd1023, 10'd1023, 10'd1023},
    '{11'd2047, 11'd2047, 10'd1023, 10'd1023, 10'd1023, 10'd1023}
  };
  localparam int FixedLen [NumFixed] = '{220, 40, 420, 250, 60};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 tick;
  logic                 out_valid;
  logic                 out_ready;
  logic                 line_valid;
  logic                 frame_sync;
  logic [PixelW-1:0]    pixel_byte;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  cfg_t                  regs;
  logic [ByteCountW-1:0] pix_count;
  logic [LineCountW-1:0] row_count;
  logic [1:0]            yuv_phase;
  beat_t                 last_beat;

  beat_t       expected_beats [$];
  beat_t       got;
  beat_t       want;
  int unsigned errors;
  int unsigned beats_checked;
  int unsigned ticks_sent;
  int unsigned idle_ticks;
  int unsigned settings_used;
  int unsigned calm_left;
  int unsigned quiet_cycles;
  bit          hold_done;

  camera_video_timing_generator_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tick       (tick),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_valid (line_valid),
    .frame_sync (frame_sync),
    .pixel_byte (pixel_byte),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [PixelW-1:0] luma_for_position(logic [ByteCountW-1:0] pos);
    if (pos < Bar1End) return Bar1Y;
    if (pos < Bar2End) return Bar2Y;
    if (pos < Bar3End) return Bar3Y;
    return Bar4Y;
  endfunction

  function automatic beat_t advance_timing(bit t);
    if (t) begin
      pix_count = pix_count + 1'b1;
      last_beat.line_valid = (pix_count < regs.active_bytes) &&
                             (row_count > regs.active_first) &&
                             (row_count < regs.active_end);
      if (pix_count > regs.line_wrap) begin
        pix_count = '0;
        row_count = row_count + 1'b1;
      end
      last_beat.frame_sync = row_count < regs.sync_lines;
      if (row_count > regs.frame_wrap) row_count = '0;
      last_beat.pixel_byte = yuv_phase[0] ? '0 : luma_for_position(pix_count);
      yuv_phase = yuv_phase + 1'b1;
    end
    return last_beat;
  endfunction

  function automatic void apply_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_ACTIVE_BYTES: regs.active_bytes = data;
      REG_LINE_WRAP:    regs.line_wrap    = data;
      REG_ACTIVE_FIRST: regs.active_first = data[VRegW-1:0];
      REG_ACTIVE_END:   regs.active_end   = data[VRegW-1:0];
      REG_SYNC_LINES:   regs.sync_lines   = data[VRegW-1:0];
      REG_FRAME_WRAP:   regs.frame_wrap   = data[VRegW-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag(string field, int unsigned exp_v, int unsigned act_v);
    $display("%0t: %s expected %0d got %0d", $time, field, exp_v, act_v);
    errors++;
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic program_timing(cfg_t c);
    write_reg(REG_ACTIVE_BYTES, c.active_bytes);
    write_reg(REG_LINE_WRAP, c.line_wrap);
    write_reg(REG_ACTIVE_FIRST, {1'($urandom_range(0, 1)), c.active_first});
    write_reg(REG_ACTIVE_END, {1'($urandom_range(0, 1)), c.active_end});
    write_reg(REG_SYNC_LINES, {1'($urandom_range(0, 1)), c.sync_lines});
    write_reg(REG_FRAME_WRAP, {1'($urandom_range(0, 1)), c.frame_wrap});
    if ($urandom_range(0, 1))
      write_reg(CfgIndexW'(NumRegs + $urandom_range(0, 1)), CfgDataW'($urandom));
    settings_used++;
  endtask

  task automatic send_step(bit t, bit known, beat_t typed);
    int unsigned gap;
    beat_t       predicted;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 120);
      gap = pick_gap();
    end
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    tick     = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_timing(t);
    expected_beats.push_back(known ? typed : predicted);
    ticks_sent++;
    if (!t) idle_ticks++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = '{line_valid, frame_sync, pixel_byte};
      if (expected_beats.size() == 0) begin
        $display("%0t: beat with nothing expected, got %0d %0d %0d",
                 $time, line_valid, frame_sync, pixel_byte);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.line_valid !== want.line_valid)
          flag("line_valid", want.line_valid, got.line_valid);
        if (got.frame_sync !== want.frame_sync)
          flag("frame_sync", want.frame_sync, got.frame_sync);
        if (got.pixel_byte !== want.pixel_byte)
          flag("pixel_byte", want.pixel_byte, got.pixel_byte);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
      $display("FAIL camera_video_timing_generator_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sink
    int unsigned stall;
    int unsigned burst;
    hold_done = 1'b0;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!hold_done && ticks_sent >= 400) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      stall = pick_gap();
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      burst = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      out_ready = 1'b1;
      repeat (burst) @(negedge clk);
    end
  end

  initial begin : stimulus
    cfg_t c;
    rst       = 1'b1;
    in_valid  = 1'b0;
    tick      = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_ACTIVE_BYTES;
    cfg_data  = '0;
    ticks_sent    = 0;
    idle_ticks    = 0;
    settings_used = 0;
    calm_left     = 0;
    regs      = '{ActiveBytesRst, LineWrapRst, ActiveFirstRst,
                  ActiveEndRst, SyncLinesRst, FrameWrapRst};
    pix_count = '0;
    row_count = '0;
    yuv_phase = '0;
    last_beat = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DirectedRows[i])
      send_step(DirectedRows[i].tick, DirectedRows[i].known, DirectedRows[i].want);

    for (int p = 0; p < NumFixed + NumRandom; p++) begin
      if (p < NumFixed) begin
        c = FixedCfg[p];
      end else begin
        c.line_wrap    = HRegW'($urandom_range(0, 12));
        c.active_bytes = HRegW'($urandom_range(0, c.line_wrap + 2));
        c.frame_wrap   = VRegW'($urandom_range(0, 8));
        c.active_first = VRegW'($urandom_range(0, 4));
        c.active_end   = VRegW'($urandom_range(0, c.frame_wrap + 2));
        c.sync_lines   = VRegW'($urandom_range(0, c.frame_wrap + 2));
      end
      drain();
      program_timing(c);
      repeat (p < NumFixed ? FixedLen[p] : RandomLen)
        send_step($urandom_range(0, 4) != 0, 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d ticks (%0d idle) over %0d register settings plus reset defaults;",
             ticks_sent, idle_ticks, settings_used);
    $display("checked %0d output beats with random stalls on both sides.", beats_checked);
    if (errors == 0) begin
      $display("PASS camera_video_timing_generator_core");
    end else begin
      $display("FAIL camera_video_timing_generator_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cvtg_pkg.sv
rtl/cvtg_cfg_regs.sv
rtl/cvtg_timing.sv
rtl/cvtg_out_buf.sv
rtl/camera_video_timing_generator_core.sv
bench/camera_video_timing_generator_core_test.sv
